@@ rtl/core/tsr_pkg.sv @@
`default_nettype none
package tsr_pkg;
    localparam int HOLD_DEPTH = 16;
    localparam int TAG_BITS = 16;
    localparam int IDX_BITS = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(HOLD_DEPTH + 1);

    typedef enum logic [1:0] {
        DISP_FWD  = 2'd0,
        DISP_HELD = 2'd1,
        DISP_DISC = 2'd2,
        DISP_DROP = 2'd3
    } disp_t;

    typedef struct packed {
        logic [31:0]         seq;
        logic [15:0]         len;
        logic                syn;
        logic                rst;
        logic [TAG_BITS-1:0] tag;
    } seg_t;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        disp_t               disposition;
        logic                last;
    } res_t;
endpackage
`default_nettype wire

@@ rtl/core/tsr_if.sv @@
`default_nettype none
interface tsr_seg_if;
    import tsr_pkg::*;
    logic valid;
    logic ready;
    seg_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tsr_res_if;
    import tsr_pkg::*;
    logic valid;
    logic ready;
    res_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tcp_segment_reorder.sv @@
`default_nettype none
// Channel   Dir  Payload
// seg       in   seq, len, syn, rst, tag
// res       out  tag, disposition, last
//
// Held segments sit in a memory behind a slot -> row pointer list, kept sorted.
// Discard, drop and the sync forward: accept, then the classify state.
// Insert: each held slot scanned passes through the emit and scan states.
// In-order forward: each drained entry takes a read wait and an emit step.
// Reset clears expected number, sync flag and count; memory needs no clearing.
// Classify and each drain step wait while a stalled result holds the output.
module tcp_segment_reorder (
    input wire logic clk,
    input wire logic rst_n,
    tsr_seg_if.sink   seg,
    tsr_res_if.source res
);
    import tsr_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLASS = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t state_reg;
    seg_t cur_reg;
    logic [31:0] exp_reg;
    logic synced_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] k_reg;
    logic [IDX_BITS-1:0] map_reg [HOLD_DEPTH];
    logic [IDX_BITS-1:0] free_reg;
    logic busy_reg, busy_next;
    logic [$bits(seg_t)-1:0] mem [HOLD_DEPTH];
    seg_t rd_reg;
    logic [IDX_BITS-1:0] rd_addr;
    logic out_valid_reg, out_valid_next;
    res_t out_reg;
    res_t stage_reg;
    logic ins_pending;
    logic cls_in_order;
    logic cls_later;
    logic drain_take;

    assign seg.ready = (state_reg == ST_IDLE) && !busy_reg;
    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

    // read address: slot k through the pointer list
    assign rd_addr = map_reg[k_reg[IDX_BITS-1:0]];
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[rd_addr];
        if (state_reg == ST_SCAN && ins_pending)
            mem[free_reg] <= cur_reg;
    end

    // scan stop: end of list or first held seq above new seq
    logic scan_stop;
    assign scan_stop = (k_reg == count_reg) || (rd_reg.seq > cur_reg.seq);
    assign ins_pending = scan_stop;

    assign cls_in_order = (cur_reg.seq == exp_reg);
    assign cls_later    = (cur_reg.seq > exp_reg);
    // held entry at slot k is due: matching or stale
    assign drain_take   = (k_reg < count_reg) && (rd_reg.seq <= exp_reg);

    function automatic logic [31:0] adv(input logic [31:0] e, input seg_t s);
        if (s.rst)      return e + {16'd0, s.len};
        else if (s.syn) return s.seq + 32'd1;
        else            return e + {16'd0, s.len};
    endfunction

    logic out_free;
    assign out_free = !out_valid_reg || res.ready;
    logic prim_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg && !res.ready;
        busy_next = 1'b0;
        unique case (state_reg)
            ST_CLASS:
            begin
                if (out_free && !(synced_reg && (cls_in_order ||
                    (cls_later && count_reg != CNT_BITS'(HOLD_DEPTH)))))
                    out_valid_next = 1'b1;
            end
            ST_SCAN:
            begin
                if (scan_stop)
                begin
                    out_valid_next = 1'b1;
                    busy_next = 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!prim_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    busy_next = !drain_take;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cur_reg <= '0;
            exp_reg <= '0;
            synced_reg <= 1'b0;
            count_reg <= '0;
            k_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            stage_reg <= '0;
            busy_reg <= 1'b0;
            prim_reg <= 1'b0;
            for (int i = 0; i < HOLD_DEPTH; i++)
                map_reg[i] <= IDX_BITS'(i);
            free_reg <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            busy_reg <= busy_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (seg.valid && seg.ready)
                    begin
                        cur_reg <= seg.data;
                        state_reg <= ST_CLASS;
                    end
                end
                ST_CLASS:
                begin
                    if (out_free)
                    begin
                        if (!synced_reg)
                        begin
                            out_reg.tag <= cur_reg.tag;
                            out_reg.last <= 1'b1;
                            if (cur_reg.syn)
                            begin
                                exp_reg <= cur_reg.seq + 32'd1;
                                synced_reg <= 1'b1;
                                out_reg.disposition <= DISP_FWD;
                            end
                            else out_reg.disposition <= DISP_DISC;
                            state_reg <= ST_IDLE;
                        end
                        else if (cls_in_order)
                        begin
                            exp_reg <= adv(exp_reg, cur_reg);
                            // hold the forward until drain decides last
                            stage_reg.tag <= cur_reg.tag;
                            stage_reg.disposition <= DISP_FWD;
                            stage_reg.last <= 1'b0;
                            prim_reg <= 1'b1;
                            k_reg <= '0;
                            state_reg <= ST_DRAIN;
                        end
                        else if (cls_later)
                        begin
                            if (count_reg == CNT_BITS'(HOLD_DEPTH))
                            begin
                                out_reg.tag <= cur_reg.tag;
                                out_reg.disposition <= DISP_DROP;
                                out_reg.last <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                k_reg <= '0;
                                free_reg <= map_reg[count_reg[IDX_BITS-1:0]];
                                state_reg <= ST_EMIT;
                            end
                        end
                        else
                        begin
                            out_reg.tag <= cur_reg.tag;
                            out_reg.disposition <= DISP_DISC;
                            out_reg.last <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT:
                    // wait state so rd_reg holds slot k
                    state_reg <= ST_SCAN;
                ST_SCAN:
                begin
                    if (scan_stop)
                    begin
                        for (int i = 1; i < HOLD_DEPTH; i++)
                            if (CNT_BITS'(i) > k_reg && CNT_BITS'(i) <= count_reg)
                                map_reg[i] <= map_reg[i-1];
                        map_reg[k_reg[IDX_BITS-1:0]] <= free_reg;
                        count_reg <= count_reg + 1'b1;
                        out_reg.tag <= cur_reg.tag;
                        out_reg.disposition <= DISP_HELD;
                        out_reg.last <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_DRAIN:
                begin
                    // rd_reg holds slot k from the cycle after k is set
                    if (prim_reg)
                    begin
                        prim_reg <= 1'b0;
                    end
                    else if (out_free)
                    begin
                        if (drain_take)
                        begin
                            // emit the staged result, stage this entry
                            out_reg <= stage_reg;
                            stage_reg.tag <= rd_reg.tag;
                            stage_reg.last <= 1'b0;
                            if (rd_reg.seq == exp_reg)
                            begin
                                exp_reg <= adv(exp_reg, rd_reg);
                                stage_reg.disposition <= DISP_FWD;
                            end
                            else stage_reg.disposition <= DISP_DISC;
                            k_reg <= k_reg + 1'b1;
                            prim_reg <= 1'b1;
                        end
                        else
                        begin
                            out_reg.tag <= stage_reg.tag;
                            out_reg.disposition <= stage_reg.disposition;
                            out_reg.last <= 1'b1;
                            for (int i = 0; i < HOLD_DEPTH; i++)
                                map_reg[i] <= map_reg[IDX_BITS'((i +
                                    int'(k_reg)) % HOLD_DEPTH)];
                            count_reg <= count_reg - k_reg;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // stage_reg keeps the latest drain result until the next step shows
    // whether it is the final one

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(HOLD_DEPTH))
        else $error("hold count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (seg.valid && seg.ready) |=> state_reg == ST_CLASS)
        else $error("accept not classified");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> $stable(out_reg))
        else $error("result changed under stall");
endmodule
`default_nettype wire

@@ verif/tcp_segment_reorder_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tcp_segment_reorder_tb;
    import tsr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Ordered record of expected results, plus a copy of the reassembly state.
    class reorder_board;
        logic [31:0]         next_seq;
        bit                  in_sync;
        logic [31:0]         store_seq [$];
        seg_t                store_seg [$];
        res_t                pending [$];
        int                  errors;

        function void clear();
            next_seq = '0;
            in_sync = 0;
            store_seq.delete();
            store_seg.delete();
            pending.delete();
            errors = 0;
        endfunction

        function void push(logic [TAG_BITS-1:0] tag, disp_t d);
            res_t r;
            r.tag = tag;
            r.disposition = d;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        function void bump(seg_t s);
            if (s.rst)
                next_seq = next_seq + 32'(s.len);
            else if (s.syn)
                next_seq = s.seq + 32'd1;
            else
                next_seq = next_seq + 32'(s.len);
        endfunction

        // Work out every result one request causes.
        function void note_request(seg_t s);
            int pos;
            if (!in_sync) begin
                if (s.syn) begin
                    next_seq = s.seq + 32'd1;
                    in_sync = 1;
                    push(s.tag, DISP_FWD);
                end
                else
                    push(s.tag, DISP_DISC);
            end
            else if (s.seq > next_seq) begin
                if (store_seq.size() >= HOLD_DEPTH)
                    push(s.tag, DISP_DROP);
                else begin
                    pos = 0;
                    while (pos < store_seq.size() && store_seq[pos] <= s.seq)
                        pos++;
                    store_seq.insert(pos, s.seq);
                    store_seg.insert(pos, s);
                    push(s.tag, DISP_HELD);
                end
            end
            else if (s.seq < next_seq)
                push(s.tag, DISP_DISC);
            else begin
                bump(s);
                push(s.tag, DISP_FWD);
                // Drain held segments up to the first gap.
                while (store_seq.size() > 0 && store_seq[0] <= next_seq) begin
                    if (store_seq[0] == next_seq) begin
                        bump(store_seg[0]);
                        push(store_seg[0].tag, DISP_FWD);
                    end
                    else
                        push(store_seg[0].tag, DISP_DISC);
                    void'(store_seq.pop_front());
                    void'(store_seg.pop_front());
                end
            end
            pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result tag=%h disp=%0d last=%b",
                         $time, got.tag, got.disposition, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.tag !== want.tag) begin
                $display("%0t: tag expected %h actual %h", $time, want.tag, got.tag);
                errors++;
            end
            if (got.disposition !== want.disposition) begin
                $display("%0t: disposition expected %0d actual %0d",
                         $time, want.disposition, got.disposition);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    tsr_seg_if seg_ch ();
    tsr_res_if res_ch ();

    tcp_segment_reorder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_ch.sink),
        .res   (res_ch.source)
    );

    reorder_board board;
    bit           calm;      // no idling in the last part of the run
    bit           stim_done;
    int           cycles;
    logic [15:0]  tag_ctr;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Check accepted results at the edge; the scoreboard sees them in order.
    always @(posedge clk) begin
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_result(res_ch.data);
        if (rst_n && seg_ch.valid && seg_ch.ready)
            board.note_request(seg_ch.data);
    end

    // Receiver: stall in random bursts, never once the run is calm.
    initial begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            res_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0) begin
                gap = $urandom_range(1, 12);
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Present one request and hold it until accepted.
    task automatic send_request(logic [31:0] sq, logic [15:0] ln, bit syn, bit rs,
                                logic [15:0] tg);
        seg_t s;
        s.seq = sq;
        s.len = ln;
        s.syn = syn;
        s.rst = rs;
        s.tag = tg;
        if (!calm && $urandom_range(0, 3) == 0) begin
            seg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        seg_ch.valid <= 1'b1;
        seg_ch.data  <= s;
        @(posedge clk);
        while (!seg_ch.ready) @(posedge clk);
    endtask

    task automatic idle_sender();
        seg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Plain segment with a fresh handle.
    task automatic send_plain(logic [31:0] sq, logic [15:0] ln);
        tag_ctr = tag_ctr + 16'd1;
        send_request(sq, ln, 1'b0, 1'b0, tag_ctr);
    endtask

    // One window: open with a SYN, then send the segments shuffled so that
    // some arrive early and are held, with duplicates and stragglers mixed in.
    task automatic run_window(int nseg);
        logic [31:0] base;
        logic [31:0] seqs [$];
        logic [15:0] lens [$];
        logic [31:0] s;
        int i;
        int j;
        logic [31:0] ts;
        logic [15:0] tl;
        base = $urandom_range(0, 3) == 0 ? 32'hFFFF_FF00 + $urandom_range(0, 200)
                                          : $urandom;
        tag_ctr = tag_ctr + 16'd1;
        send_request(base, 16'($urandom), 1'b1, 1'($urandom), tag_ctr);
        s = base + 32'd1;
        for (i = 0; i < nseg; i++) begin
            seqs.push_back(s);
            lens.push_back(16'($urandom_range(1, 1500)));
            s = s + 32'(lens[i]);
        end
        // Local shuffle keeps the gaps moderate.
        for (i = 0; i < nseg - 1; i++) begin
            j = i + $urandom_range(0, (nseg - 1 - i) < 4 ? nseg - 1 - i : 4);
            ts = seqs[i]; seqs[i] = seqs[j]; seqs[j] = ts;
            tl = lens[i]; lens[i] = lens[j]; lens[j] = tl;
        end
        for (i = 0; i < nseg; i++) begin
            case ($urandom_range(0, 9))
                0: send_plain(32'($urandom), 16'($urandom));  // noise
                1: send_plain(seqs[i], lens[i]);              // duplicate
                default: ;
            endcase
            tag_ctr = tag_ctr + 16'd1;
            send_request(seqs[i], lens[i], 1'b0, $urandom_range(0, 7) == 0, tag_ctr);
        end
    endtask

    initial begin
        int i;
        board = new();
        board.clear();
        calm = 0;
        stim_done = 0;
        tag_ctr = 16'h0100;
        rst_n = 1'b0;
        seg_ch.valid = 1'b0;
        seg_ch.data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: traffic before sync is discarded, RST without SYN too.
        send_request(32'h0000_0000, 16'h0000, 1'b0, 1'b0, 16'h0000);
        send_request(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF);
        // SYN with RST while unsynced still syncs.
        send_request(32'h0000_1000, 16'hFFFF, 1'b1, 1'b1, 16'hAAAA);
        // Expected is now 0x1001. Hold later ones, equal sequences included.
        send_request(32'h0000_1011, 16'h0010, 1'b0, 1'b0, 16'h5555);
        send_request(32'h0000_1011, 16'h0004, 1'b0, 1'b0, 16'h0001);
        send_request(32'h0000_1005, 16'h0000, 1'b0, 1'b0, 16'h0002);
        send_request(32'h0000_1003, 16'h0002, 1'b0, 1'b0, 16'h0003);
        send_request(32'h0000_0FFF, 16'h0001, 1'b0, 1'b0, 16'h0004); // earlier
        // In order: forward, discard stale 1003, forward zero-length 1005.
        send_request(32'h0000_1001, 16'h0004, 1'b0, 1'b0, 16'h0005);
        // Fill the store to overflow, then drop.
        for (i = 0; i < HOLD_DEPTH + 2; i++)
            send_request(32'h0000_2000 + 32'(i), 16'h0001, 1'b0, 1'b0, 16'(16'h0100 + i));
        // Zero-length in-order leaves expected; a SYN re-bases it.
        send_request(32'h0000_1005, 16'h0000, 1'b0, 1'b0, 16'h0006);
        send_request(32'h0000_1005, 16'h0000, 1'b1, 1'b0, 16'h0007);
        send_request(32'h0000_1006, 16'h0FFA, 1'b0, 1'b0, 16'h0008);
        send_request(32'h0000_2000, 16'h0000, 1'b1, 1'b0, 16'h0009);

        // Random windows, roughly 100 requests in all; last stretch calm.
        for (i = 0; i < 11; i++) begin
            if (i == 8)
                calm = 1;
            run_window($urandom_range(4, 10));
        end
        idle_sender();
        stim_done = 1;
    end

    // Watch for the end or a hang.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
            if (stim_done && board.pending.size() == 0) begin
                repeat (40) @(posedge clk);
                if (board.errors == 0 && board.pending.size() == 0)
                    $display("Simulation PASSED");
                else
                    $display("Simulation FAILED");
                $finish;
            end
        end
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/tsr_pkg.sv
rtl/core/tsr_if.sv
rtl/core/tcp_segment_reorder.sv
verif/tcp_segment_reorder_tb.sv
